### src/cdll_pkg.sv
package cdll_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [3:0] CMD_QUERY      = 4'd0;
    localparam logic [3:0] CMD_PREV       = 4'd1;
    localparam logic [3:0] CMD_NEXT       = 4'd2;
    localparam logic [3:0] CMD_FIRST      = 4'd3;
    localparam logic [3:0] CMD_LAST       = 4'd4;
    localparam logic [3:0] CMD_DELETE     = 4'd5;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd6;
    localparam logic [3:0] CMD_INS_AFTER  = 4'd7;
    localparam logic [3:0] CMD_WRITE_CUR  = 4'd8;
    localparam logic [3:0] CMD_READ_IDX   = 4'd9;
    localparam logic [3:0] CMD_WRITE_IDX  = 4'd10;
    localparam logic [3:0] CMD_CLEAR      = 4'd11;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TAKE,
        ST_LINK,
        ST_LINK2,
        ST_DEL2,
        ST_WALK,
        ST_WALKW,
        ST_OUT,
        ST_RES
    } state_t;

endpackage

### src/cursor_doubly_linked_list.sv
// Doubly linked list with a cursor, slots held in three registered-read RAMs
// (values, next links, prev links) plus a free-slot chain.
// Input channel s_axis_*: one command per request (cmd, item_value,
// position). Output channel m_axis_*: one result per command (element,
// moved flag, status, item count after the command).
// Commands are processed one at a time; s_axis_tready is high only while
// the controller is idle. Deletes from the middle and inserts pass through
// extra link-update states; read_idx and write_idx walk the list from the
// head, one link read per hop. After each result the controller returns to idle.
// The result sits in an output register; the controller accepts the next
// command while it waits, and stalls only when a second result is ready
// before the first is taken.
// Reset empties the list immediately; RAM contents need no clearing.
module cursor_doubly_linked_list
    import cdll_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] cmd, [35:4] item_value, [43:36] position, [47:44] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] element_out, [32] moved, [34:33] status, [43:35] item_count, [47:44] zero
    output logic [47:0] m_axis_tdata
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    logic [3:0]             cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [7:0]             pos_reg, pos_next;
    logic [SW-1:0]          head_reg, head_next;
    logic [SW-1:0]          tail_reg, tail_next;
    logic [SW-1:0]          cursor_reg, cursor_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [SW-1:0]          free_head_reg, free_head_next;
    logic [CW-1:0]          freed_reg, freed_next;
    logic [CW-1:0]          fresh_reg, fresh_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic [SW-1:0]          p_reg, p_next;
    logic [SW-1:0]          n_reg, n_next;
    logic [7:0]             k_reg, k_next;
    logic                   moved_reg, moved_next;
    logic [1:0]             status_reg, status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_element_reg, out_element_next;
    logic                   out_moved_reg, out_moved_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [8:0]             out_count_reg, out_count_next;

    logic                   val_we;
    logic [SW-1:0]          val_waddr, val_raddr;
    logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
    logic                   nxt_we;
    logic [SW-1:0]          nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
    logic                   prv_we;
    logic [SW-1:0]          prv_waddr, prv_raddr, prv_wdata, prv_rdata;

    cdll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram
    (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    cdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram
    (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    cdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram
    (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (prv_raddr),
        .rdata (prv_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_count_reg, out_status_reg, out_moved_reg,
                            out_element_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= CMD_QUERY;
            val_reg         <= '0;
            pos_reg         <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            cursor_reg      <= '0;
            count_reg       <= '0;
            free_head_reg   <= '0;
            freed_reg       <= '0;
            fresh_reg       <= '0;
            slot_reg        <= '0;
            p_reg           <= '0;
            n_reg           <= '0;
            k_reg           <= '0;
            moved_reg       <= 1'b0;
            status_reg      <= STATUS_OK;
            out_valid_reg   <= 1'b0;
            out_element_reg <= '0;
            out_moved_reg   <= 1'b0;
            out_status_reg  <= STATUS_OK;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            val_reg         <= val_next;
            pos_reg         <= pos_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            cursor_reg      <= cursor_next;
            count_reg       <= count_next;
            free_head_reg   <= free_head_next;
            freed_reg       <= freed_next;
            fresh_reg       <= fresh_next;
            slot_reg        <= slot_next;
            p_reg           <= p_next;
            n_reg           <= n_next;
            k_reg           <= k_next;
            moved_reg       <= moved_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
            out_element_reg <= out_element_next;
            out_moved_reg   <= out_moved_next;
            out_status_reg  <= out_status_next;
            out_count_reg   <= out_count_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        val_next         = val_reg;
        pos_next         = pos_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cursor_next      = cursor_reg;
        count_next       = count_reg;
        free_head_next   = free_head_reg;
        freed_next       = freed_reg;
        fresh_next       = fresh_reg;
        slot_next        = slot_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        k_next           = k_reg;
        moved_next       = moved_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg;
        out_element_next = out_element_reg;
        out_moved_next   = out_moved_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;

        val_we    = 1'b0;
        val_waddr = cursor_reg;
        val_wdata = val_reg;
        val_raddr = cursor_reg;
        nxt_we    = 1'b0;
        nxt_waddr = cursor_reg;
        nxt_wdata = free_head_reg;
        nxt_raddr = cursor_reg;
        prv_we    = 1'b0;
        prv_waddr = cursor_reg;
        prv_wdata = slot_reg;
        prv_raddr = cursor_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // links of the cursor slot are fetched while waiting
                if (s_axis_tvalid)
                begin
                    cmd_next    = s_axis_tdata[3:0];
                    val_next    = VALUE_WIDTH'(s_axis_tdata[35:4]);
                    pos_next    = s_axis_tdata[43:36];
                    moved_next  = 1'b0;
                    status_next = STATUS_OK;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                p_next     = prv_rdata;
                n_next     = nxt_rdata;
                nxt_raddr  = free_head_reg;
                state_next = ST_OUT;
                case (cmd_reg)
                    CMD_PREV, CMD_NEXT, CMD_FIRST, CMD_LAST, CMD_DELETE, CMD_WRITE_CUR:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            case (cmd_reg)
                                CMD_PREV:
                                begin
                                    if (cursor_reg != head_reg)
                                    begin
                                        cursor_next = prv_rdata;
                                        moved_next  = 1'b1;
                                    end
                                end
                                CMD_NEXT:
                                begin
                                    if (cursor_reg != tail_reg)
                                    begin
                                        cursor_next = nxt_rdata;
                                        moved_next  = 1'b1;
                                    end
                                end
                                CMD_FIRST:
                                begin
                                    cursor_next = head_reg;
                                end
                                CMD_LAST:
                                begin
                                    cursor_next = tail_reg;
                                end
                                CMD_WRITE_CUR:
                                begin
                                    val_we = 1'b1;
                                end
                                default:
                                begin
                                    // delete: push the slot onto the free chain
                                    nxt_we         = 1'b1;
                                    free_head_next = cursor_reg;
                                    freed_next     = freed_reg + 1'b1;
                                    count_next     = count_reg - 1'b1;
                                    if (count_reg == CW'(1))
                                    begin
                                        head_next   = '0;
                                        tail_next   = '0;
                                        cursor_next = '0;
                                    end
                                    else if (cursor_reg == head_reg)
                                    begin
                                        head_next   = nxt_rdata;
                                        cursor_next = nxt_rdata;
                                    end
                                    else if (cursor_reg == tail_reg)
                                    begin
                                        tail_next   = prv_rdata;
                                        cursor_next = prv_rdata;
                                    end
                                    else
                                    begin
                                        cursor_next = nxt_rdata;
                                        state_next  = ST_DEL2;
                                    end
                                end
                            endcase
                        end
                    end

                    CMD_INS_BEFORE, CMD_INS_AFTER:
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (freed_reg != '0)
                        begin
                            slot_next  = free_head_reg;
                            state_next = ST_TAKE;
                        end
                        else
                        begin
                            slot_next  = SW'(fresh_reg);
                            fresh_next = fresh_reg + 1'b1;
                            state_next = ST_LINK;
                        end
                    end

                    CMD_READ_IDX, CMD_WRITE_IDX:
                    begin
                        if (32'(pos_reg) >= 32'(count_reg))
                        begin
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            slot_next  = head_reg;
                            k_next     = '0;
                            state_next = ST_WALK;
                        end
                    end

                    CMD_CLEAR:
                    begin
                        head_next      = '0;
                        tail_next      = '0;
                        cursor_next    = '0;
                        count_next     = '0;
                        free_head_next = '0;
                        freed_next     = '0;
                        fresh_next     = '0;
                    end

                    default:
                    begin
                        // unused codes behave as query but never flag empty
                        if (cmd_reg == CMD_QUERY && count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                    end
                endcase
            end

            ST_TAKE:
            begin
                free_head_next = nxt_rdata;
                freed_next     = freed_reg - 1'b1;
                state_next     = ST_LINK;
            end

            ST_LINK:
            begin
                val_we    = 1'b1;
                val_waddr = slot_reg;
                if (count_reg == '0)
                begin
                    head_next   = slot_reg;
                    tail_next   = slot_reg;
                    cursor_next = slot_reg;
                    count_next  = count_reg + 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = slot_reg;
                    prv_we    = 1'b1;
                    prv_waddr = slot_reg;
                    if (cmd_reg == CMD_INS_BEFORE)
                    begin
                        nxt_wdata = cursor_reg;
                        prv_wdata = p_reg;
                    end
                    else
                    begin
                        nxt_wdata = n_reg;
                        prv_wdata = cursor_reg;
                    end
                    state_next = ST_LINK2;
                end
            end

            ST_LINK2:
            begin
                count_next = count_reg + 1'b1;
                nxt_wdata  = slot_reg;
                prv_wdata  = slot_reg;
                if (cmd_reg == CMD_INS_BEFORE)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = cursor_reg;
                    if (cursor_reg == head_reg)
                    begin
                        head_next = slot_reg;
                    end
                    else
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = p_reg;
                    end
                end
                else
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = cursor_reg;
                    if (cursor_reg == tail_reg)
                    begin
                        tail_next = slot_reg;
                    end
                    else
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = n_reg;
                    end
                end
                state_next = ST_OUT;
            end

            ST_DEL2:
            begin
                nxt_we     = 1'b1;
                nxt_waddr  = p_reg;
                nxt_wdata  = n_reg;
                prv_we     = 1'b1;
                prv_waddr  = n_reg;
                prv_wdata  = p_reg;
                state_next = ST_OUT;
            end

            ST_WALK:
            begin
                if (k_reg == pos_reg)
                begin
                    if (cmd_reg == CMD_WRITE_IDX)
                    begin
                        val_we     = 1'b1;
                        val_waddr  = slot_reg;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // read the indexed value straight into the result
                        val_raddr  = slot_reg;
                        state_next = ST_RES;
                    end
                end
                else
                begin
                    nxt_raddr  = slot_reg;
                    state_next = ST_WALKW;
                end
            end

            ST_WALKW:
            begin
                slot_next  = nxt_rdata;
                k_next     = k_reg + 1'b1;
                state_next = ST_WALK;
            end

            ST_OUT:
            begin
                state_next = ST_RES;
            end

            ST_RES:
            begin
                val_raddr = slot_reg;
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_element_next = (count_reg == '0) ? 32'd0 : 32'(val_rdata);
                    out_moved_next   = moved_reg;
                    out_status_next  = status_reg;
                    out_count_next   = 9'(count_reg);
                    state_next       = ST_IDLE;
                end
                else
                begin
                    // hold the read data by re-reading the same slot
                    if (!(cmd_reg == CMD_READ_IDX && status_reg == STATUS_OK))
                    begin
                        val_raddr = cursor_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/cdll_ram.sv
module cdll_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
